// ===== hdl/lrp_pkg.sv =====
`default_nettype none
package lrp_pkg;

   // Input transaction commands
   localparam logic [1:0] CMD_BYTE    = 2'd0;
   localparam logic [1:0] CMD_EXPECT  = 2'd1;
   localparam logic [1:0] CMD_HALT    = 2'd2;
   localparam logic [1:0] CMD_TIMEOUT = 2'd3;

   // Awaited response kinds
   localparam logic [1:0] KIND_SCAN   = 2'd0;
   localparam logic [1:0] KIND_HEALTH = 2'd1;
   localparam logic [1:0] KIND_INFO   = 2'd2;

   // Result kinds
   localparam logic [1:0] RES_SCAN   = 2'd0;
   localparam logic [1:0] RES_HEALTH = 2'd1;
   localparam logic [1:0] RES_INFO   = 2'd2;
   localparam logic [1:0] RES_ERROR  = 2'd3;

   // Error status codes
   localparam logic [1:0] ERR_LENGTH  = 2'd0;
   localparam logic [1:0] ERR_TYPE    = 2'd1;
   localparam logic [1:0] ERR_TIMEOUT = 2'd2;

   // Health status saturates to unknown above error
   localparam logic [7:0] HEALTH_STATUS_MAX = 8'd2;
   localparam logic [1:0] HEALTH_UNKNOWN    = 2'd3;

   // Descriptor constants
   localparam logic [7:0]  SYNC_FIRST  = 8'hA5;
   localparam logic [7:0]  SYNC_SECOND = 8'h5A;
   localparam logic [7:0]  SCAN_TYPE   = 8'h81;
   localparam logic [29:0] HEALTH_LEN  = 30'd3;
   localparam logic [29:0] INFO_LEN    = 30'd20;

   // Byte positions (zero based) of the last byte of each section
   localparam logic [4:0] DESC_LAST   = 5'd4;
   localparam logic [4:0] HEALTH_LAST = 5'd2;
   localparam logic [4:0] INFO_LAST   = 5'd19;
   localparam logic [4:0] NODE_LAST   = 5'd4;

   localparam int STORE_DEPTH = 20;

   localparam int FRAME_COUNT_WIDTH_DEFAULT = 16;

   // One result transaction
   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  quality;
      logic        new_scan;
      logic [14:0] angle_fine;
      logic [15:0] distance_fine;
      logic [15:0] frame_index;
      logic [1:0]  status_code;
      logic [15:0] health_fault;
      logic [31:0] device_ids;
      logic [63:0] serial_low;
      logic [63:0] serial_high;
   } result_type;

endpackage
`default_nettype wire

// ===== hdl/lrp_decoder.sv =====
`default_nettype none
module lrp_decoder #(
   parameter int FRAME_COUNT_WIDTH = lrp_pkg::FRAME_COUNT_WIDTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_accept,
   input  wire logic [1:0]         command,
   input  wire logic [7:0]         rx_byte,
   input  wire logic [1:0]         expect_kind,
   output logic                    result_valid,
   output lrp_pkg::result_type     result
);

   typedef enum logic [5:0] {
      PH_IDLE    = 6'b000001,
      PH_SYNC1   = 6'b000010,
      PH_SYNC2   = 6'b000100,
      PH_DESC    = 6'b001000,
      PH_PAYLOAD = 6'b010000,
      PH_SCAN    = 6'b100000
   } phase_type;

   phase_type                    phase_ff, phase_in;
   logic [1:0]                   kind_ff, kind_in;
   logic [4:0]                   pos_ff, pos_in;
   logic [29:0]                  len_ff, len_in;
   logic [FRAME_COUNT_WIDTH-1:0] frame_ff, frame_in;
   logic                         has_pts_ff, has_pts_in;
   logic [7:0]                   store_ff [lrp_pkg::STORE_DEPTH];
   logic [7:0]                   store_in [lrp_pkg::STORE_DEPTH];
   logic                         store_wr;
   logic                         node_new;

   // Merge the incoming byte into the payload store
   always_comb begin
      for (int i = 0; i < lrp_pkg::STORE_DEPTH; i++) begin
         store_in[i] = (store_wr && pos_ff == 5'(i)) ? rx_byte : store_ff[i];
      end
   end

   assign node_new = store_in[0][1] & ~store_in[0][0];

   // Next state and result for one transaction
   always_comb begin
      phase_in     = phase_ff;
      kind_in      = kind_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      frame_in     = frame_ff;
      has_pts_in   = has_pts_ff;
      store_wr     = 1'b0;
      result_valid = 1'b0;
      result       = '0;
      if (item_accept) begin
         case (command)
            lrp_pkg::CMD_EXPECT: begin
               if (expect_kind <= lrp_pkg::KIND_INFO) begin
                  kind_in    = expect_kind;
                  phase_in   = PH_SYNC1;
                  pos_in     = '0;
                  has_pts_in = 1'b0;
               end
            end
            lrp_pkg::CMD_HALT: begin
               phase_in   = PH_IDLE;
               pos_in     = '0;
               has_pts_in = 1'b0;
            end
            lrp_pkg::CMD_TIMEOUT: begin
               if (phase_ff == PH_SCAN) begin
                  // drop the partial node, keep streaming
                  pos_in = '0;
               end else if (phase_ff != PH_IDLE) begin
                  result_valid       = 1'b1;
                  result.result_kind = lrp_pkg::RES_ERROR;
                  result.status_code = lrp_pkg::ERR_TIMEOUT;
                  phase_in           = PH_IDLE;
                  pos_in             = '0;
               end
            end
            default: begin
               case (phase_ff)
                  PH_SYNC1: begin
                     if (rx_byte == lrp_pkg::SYNC_FIRST) begin
                        phase_in = PH_SYNC2;
                     end
                  end
                  PH_SYNC2: begin
                     if (rx_byte == lrp_pkg::SYNC_SECOND) begin
                        phase_in = PH_DESC;
                        pos_in   = '0;
                        len_in   = '0;
                     end else if (rx_byte != lrp_pkg::SYNC_FIRST) begin
                        phase_in = PH_SYNC1;
                     end
                  end
                  PH_DESC: begin
                     // gather the little-endian length, then on the type byte check the type (scan) or the length
                     case (pos_ff[2:0])
                        3'd0: len_in[7:0]   = rx_byte;
                        3'd1: len_in[15:8]  = rx_byte;
                        3'd2: len_in[23:16] = rx_byte;
                        3'd3: len_in[29:24] = rx_byte[5:0];
                        default: ;
                     endcase
                     pos_in = pos_ff + 5'd1;
                     if (pos_ff == lrp_pkg::DESC_LAST) begin
                        pos_in = '0;
                        if (kind_ff == lrp_pkg::KIND_SCAN) begin
                           if (rx_byte != lrp_pkg::SCAN_TYPE) begin
                              result_valid       = 1'b1;
                              result.result_kind = lrp_pkg::RES_ERROR;
                              result.status_code = lrp_pkg::ERR_TYPE;
                              phase_in           = PH_IDLE;
                           end else begin
                              phase_in = PH_SCAN;
                           end
                        end else if ((kind_ff == lrp_pkg::KIND_HEALTH &&
                                      len_ff != lrp_pkg::HEALTH_LEN) ||
                                     (kind_ff != lrp_pkg::KIND_HEALTH &&
                                      len_ff != lrp_pkg::INFO_LEN)) begin
                           result_valid       = 1'b1;
                           result.result_kind = lrp_pkg::RES_ERROR;
                           result.status_code = lrp_pkg::ERR_LENGTH;
                           phase_in           = PH_IDLE;
                        end else begin
                           phase_in = PH_PAYLOAD;
                        end
                     end
                  end
                  PH_PAYLOAD: begin
                     store_wr = 1'b1;
                     pos_in   = pos_ff + 5'd1;
                     if (kind_ff == lrp_pkg::KIND_HEALTH) begin
                        if (pos_ff == lrp_pkg::HEALTH_LAST) begin
                           result_valid        = 1'b1;
                           result.result_kind  = lrp_pkg::RES_HEALTH;
                           result.status_code  =
                              (store_in[0] > lrp_pkg::HEALTH_STATUS_MAX) ?
                              lrp_pkg::HEALTH_UNKNOWN : store_in[0][1:0];
                           result.health_fault = {store_in[2], store_in[1]};
                           phase_in            = PH_IDLE;
                           pos_in              = '0;
                        end
                     end else if (pos_ff == lrp_pkg::INFO_LAST) begin
                        result_valid       = 1'b1;
                        result.result_kind = lrp_pkg::RES_INFO;
                        for (int i = 0; i < 4; i++) begin
                           result.device_ids[8*i +: 8] = store_in[i];
                        end
                        for (int i = 0; i < 8; i++) begin
                           result.serial_low[8*i +: 8]  = store_in[4 + i];
                           result.serial_high[8*i +: 8] = store_in[12 + i];
                        end
                        phase_in = PH_IDLE;
                        pos_in   = '0;
                     end
                  end
                  PH_SCAN: begin
                     store_wr = 1'b1;
                     pos_in   = pos_ff + 5'd1;
                     if (pos_ff == lrp_pkg::NODE_LAST) begin
                        pos_in = '0;
                        // a new-scan node closes a frame that holds points
                        if (node_new && has_pts_ff) begin
                           frame_in = frame_ff + FRAME_COUNT_WIDTH'(1);
                        end
                        has_pts_in           = 1'b1;
                        result_valid         = 1'b1;
                        result.result_kind   = lrp_pkg::RES_SCAN;
                        result.quality       = {store_in[0][7:2], 2'b00};
                        result.new_scan      = node_new;
                        result.angle_fine    = {store_in[2], store_in[1][7:1]};
                        result.distance_fine = {store_in[4], store_in[3]};
                        result.frame_index   = 16'(frame_in);
                     end
                  end
                  default: ;
               endcase
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         kind_ff    <= lrp_pkg::KIND_SCAN;
         pos_ff     <= '0;
         len_ff     <= '0;
         frame_ff   <= '0;
         has_pts_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         kind_ff    <= kind_in;
         pos_ff     <= pos_in;
         len_ff     <= len_in;
         frame_ff   <= frame_in;
         has_pts_ff <= has_pts_in;
      end
   end

   // Payload bytes
   always_ff @(posedge clock) begin
      for (int i = 0; i < lrp_pkg::STORE_DEPTH; i++) begin
         store_ff[i] <= store_in[i];
      end
   end

endmodule
`default_nettype wire

// ===== hdl/lrp_out_queue.sv =====
`default_nettype none
module lrp_out_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire lrp_pkg::result_type push_data,
   output logic                     has_room,
   output logic                     pop_valid,
   input  wire logic                pop_ready,
   output lrp_pkg::result_type      pop_data
);

   lrp_pkg::result_type head_ff, head_in;
   lrp_pkg::result_type tail_ff, tail_in;
   logic [1:0]          count_ff, count_in;
   logic                pop;

   assign has_room  = (count_ff != 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = head_ff;
   assign pop       = pop_valid & pop_ready;

   // Shift out on a taken transaction, append a new result behind
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      case ({push, pop})
         2'b11: begin
            if (count_ff == 2'd1) begin
               head_in = push_data;
            end else begin
               head_in = tail_ff;
               tail_in = push_data;
            end
         end
         2'b01: begin
            head_in  = tail_ff;
            count_in = count_ff - 2'd1;
         end
         2'b10: begin
            if (count_ff == 2'd0) begin
               head_in = push_data;
            end else begin
               tail_in = push_data;
            end
            count_in = count_ff + 2'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule
`default_nettype wire

// ===== hdl/lidar_response_parser_core.sv =====
// Each result transaction is registered in the result queue and leaves on rsp in order.
// Throughput: one request transaction per cycle while the queue has room; each byte is decoded in the accept cycle.
// A two-entry result queue keeps req_tready high while one result waits on rsp_tready.
// Reset (synchronous, active high) returns to idle, frame number zero, result queue empty.
`default_nettype none
module lidar_response_parser_core #(
   parameter int FRAME_COUNT_WIDTH = lrp_pkg::FRAME_COUNT_WIDTH_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [15:0]  req_tdata,  // rx_byte[7:0], expect_kind[9:8], zero[15:10]
   input  wire logic [1:0]   req_tuser,  // command[1:0]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [239:0]      rsp_tdata,  // quality[7:0], new_scan[8], angle_fine[23:9],
                                         // distance_fine[39:24], frame_index[55:40],
                                         // status_code[57:56], health_fault[73:58],
                                         // device_ids[105:74], serial_low[169:106],
                                         // serial_high[233:170], zero[239:234]
   output logic [1:0]        rsp_tuser   // result_kind[1:0]
);

   logic                item_accept;
   logic                result_valid;
   lrp_pkg::result_type result;
   lrp_pkg::result_type head;

   assign item_accept = req_tvalid & req_tready;

   lrp_decoder #(
      .FRAME_COUNT_WIDTH(FRAME_COUNT_WIDTH)
   ) u_decoder (
      .clock        (clock),
      .reset        (reset),
      .item_accept  (item_accept),
      .command      (req_tuser),
      .rx_byte      (req_tdata[7:0]),
      .expect_kind  (req_tdata[9:8]),
      .result_valid (result_valid),
      .result       (result)
   );

   lrp_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (item_accept & result_valid),
      .push_data (result),
      .has_room  (req_tready),
      .pop_valid (rsp_tvalid),
      .pop_ready (rsp_tready),
      .pop_data  (head)
   );

   // Pack the result fields onto the stream
   assign rsp_tuser = head.result_kind;
   assign rsp_tdata = {6'd0, head.serial_high, head.serial_low, head.device_ids,
                       head.health_fault, head.status_code, head.frame_index,
                       head.distance_fine, head.angle_fine, head.new_scan, head.quality};

endmodule
`default_nettype wire
